// ===== rtl/abmc_pkg.sv =====
// Package with payload types, constants and helpers for the appliance button menu controller.
package abmc_pkg;

  localparam int unsigned MENU_ENTRIES   = 4;
  localparam int unsigned OPTION_ENTRIES = 3;
  localparam int unsigned OPTION_BITS    = 3;
  localparam int unsigned KEY_SOUND_OFF_BIT = 2;

  localparam logic [6:0] MAX_TARGET  = 7'd90;
  localparam logic [6:0] MAX_HOURS   = 7'd99;
  localparam logic [5:0] MAX_MINUTES = 6'd59;
  localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;

  // Reciprocal of 60 scaled by 2^19; exact quotient for any 13-bit value.
  localparam logic [13:0] RECIP_60    = 14'd8739;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [1:0] MENU_DISPLAY = 2'd0;
  localparam logic [1:0] MENU_TARGET  = 2'd1;
  localparam logic [1:0] MENU_HOURS   = 2'd2;
  localparam logic [1:0] MENU_MINUTES = 2'd3;

  typedef struct packed {
    logic        power_press;
    logic        menu_release;
    logic        menu_long_press;
    logic        up_release;
    logic        up_repeat;
    logic        down_release;
    logic        down_repeat;
    logic        menu_held;
    logic [12:0] remaining_in;
  } poll_t;

  typedef struct packed {
    logic        powered;
    logic        display_on;
    logic        settings_active;
    logic        countdown_halted;
    logic [1:0]  menu_position;
    logic [6:0]  target_temperature;
    logic [12:0] timer_preset;
    logic [12:0] remaining_out;
    logic        seconds_reload;
    logic [1:0]  beep_count;
    logic        screen_clear;
    logic [2:0]  option_bits;
  } result_t;

  // Steps a menu position and wraps it into the given number of entries.
  function automatic logic [1:0] wrap_index(logic [1:0] idx, int unsigned entries);
    logic [2:0] v;
    logic [2:0] n;
    v = {1'b0, idx} + 3'd1;
    n = 3'(entries);
    for (int i = 0; i < 4; i++) begin
      if (v >= n) begin
        v = v - n;
      end
    end
    return v[1:0];
  endfunction

endpackage

// ===== rtl/appliance_button_menu_controller_unit.sv =====
// Top level of the appliance button menu controller: poll decode, state and result register.
//
//   channel  | signals                             | direction | carries
//   poll     | poll_valid, poll_ready, poll        | in        | one button poll per beat
//   result   | result_valid, result_ready, result  | out       | one result per poll
//
// A poll is decoded in the cycle it is accepted and its result is shown in the next cycle.
// One poll per cycle is sustained while result_ready stays high; the only storage is the state and one result register.
// poll_ready is high whenever the result register is empty or is being drained this cycle.
// Reset clears all flags, the menu position, the stores and result_valid; the result data register is not reset.
module appliance_button_menu_controller_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             poll_valid,
  output logic             poll_ready,
  input  abmc_pkg::poll_t  poll,
  output logic             result_valid,
  input  logic             result_ready,
  output abmc_pkg::result_t result
);

  typedef struct packed {
    logic [6:0] tgt;
    logic [6:0] hrs;
    logic [5:0] mins;
    logic       touched;
  } adjust_t;

  logic        power_flag, power_flag_next;
  logic        display_flag, display_flag_next;
  logic        settings_flag, settings_flag_next;
  logic        halted_flag, halted_flag_next;
  logic [1:0]  menu_index, menu_index_next;
  logic [6:0]  target_store, target_store_next;
  logic [12:0] preset_store, preset_store_next;
  logic [2:0]  option_store, option_store_next;

  logic [26:0] quot_prod;
  logic [7:0]  hrs_raw;
  logic [12:0] hrs_minutes;
  logic [5:0]  mins_raw;
  logic [6:0]  hrs_sat;

  logic        accept;
  logic        key_beep;
  logic        up_event;
  logic        down_event;
  adjust_t     adj;
  logic [12:0] rem;
  logic        reload;
  logic [1:0]  beeps;
  logic        clr;
  abmc_pkg::result_t result_next;

  function automatic adjust_t adjust_step(adjust_t a, logic up, logic [1:0] idx);
    adjust_t r;
    r = a;
    unique case (idx)
      abmc_pkg::MENU_TARGET: begin
        if (up) begin
          if (a.tgt < abmc_pkg::MAX_TARGET) r.tgt = a.tgt + 7'd1;
        end else begin
          if (a.tgt != 7'd0) r.tgt = a.tgt - 7'd1;
        end
      end
      abmc_pkg::MENU_HOURS: begin
        r.touched = 1'b1;
        if (up) r.hrs = (a.hrs < abmc_pkg::MAX_HOURS) ? a.hrs + 7'd1 : 7'd0;
        else    r.hrs = (a.hrs != 7'd0) ? a.hrs - 7'd1 : abmc_pkg::MAX_HOURS;
      end
      abmc_pkg::MENU_MINUTES: begin
        r.touched = 1'b1;
        if (up) r.mins = (a.mins < abmc_pkg::MAX_MINUTES) ? a.mins + 6'd1 : 6'd0;
        else    r.mins = (a.mins != 6'd0) ? a.mins - 6'd1 : abmc_pkg::MAX_MINUTES;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  assign poll_ready = !result_valid || result_ready;
  assign accept     = poll_valid && poll_ready;

  assign quot_prod   = 27'(poll.remaining_in) * 27'(abmc_pkg::RECIP_60);
  assign hrs_raw     = quot_prod[26:abmc_pkg::RECIP_SHIFT];
  assign hrs_minutes = 13'(hrs_raw) * 13'(abmc_pkg::MINUTES_PER_HOUR);
  assign mins_raw    = 6'(poll.remaining_in - hrs_minutes);
  assign hrs_sat     = (hrs_raw > 8'(abmc_pkg::MAX_HOURS)) ? abmc_pkg::MAX_HOURS : hrs_raw[6:0];

  assign key_beep   = !option_store[abmc_pkg::KEY_SOUND_OFF_BIT];
  assign up_event   = poll.up_release || poll.up_repeat;
  assign down_event = poll.down_release || poll.down_repeat;

  always_comb begin
    power_flag_next    = power_flag;
    display_flag_next  = display_flag;
    settings_flag_next = settings_flag;
    halted_flag_next   = halted_flag;
    menu_index_next    = menu_index;
    target_store_next  = target_store;
    preset_store_next  = preset_store;
    option_store_next  = option_store;
    rem     = poll.remaining_in;
    reload  = 1'b0;
    beeps   = 2'd0;
    clr     = 1'b0;
    adj.tgt     = target_store;
    adj.hrs     = hrs_sat;
    adj.mins    = mins_raw;
    adj.touched = 1'b0;

    if (settings_flag) begin
      if (poll.power_press) begin
        power_flag_next    = 1'b0;
        display_flag_next  = 1'b0;
        settings_flag_next = 1'b0;
        halted_flag_next   = 1'b1;
        clr                = 1'b1;
      end else if (poll.menu_release) begin
        menu_index_next = abmc_pkg::wrap_index(menu_index, abmc_pkg::OPTION_ENTRIES);
      end else if (poll.up_release || poll.down_release) begin
        if (menu_index < 2'(abmc_pkg::OPTION_BITS)) begin
          option_store_next = option_store ^ (3'b001 << menu_index);
        end
      end
    end else if (poll.power_press) begin
      if (power_flag) begin
        beeps              = 2'(key_beep);
        power_flag_next    = 1'b0;
        display_flag_next  = 1'b0;
        settings_flag_next = 1'b0;
        halted_flag_next   = 1'b1;
        clr                = 1'b1;
      end else if (poll.menu_held) begin
        settings_flag_next = 1'b1;
        power_flag_next    = 1'b1;
        display_flag_next  = 1'b1;
        halted_flag_next   = 1'b0;
      end else begin
        beeps             = 2'(key_beep);
        power_flag_next   = 1'b1;
        display_flag_next = 1'b1;
        halted_flag_next  = 1'b0;
        rem               = (preset_store != 13'd0) ? preset_store : 13'd1;
        reload            = 1'b1;
      end
    end else if (power_flag) begin
      if (!display_flag) begin
        if (poll.up_release || poll.down_release || poll.menu_release) begin
          beeps             = 2'(key_beep);
          display_flag_next = 1'b1;
        end
      end else if (poll.menu_long_press) begin
        beeps             = 2'(key_beep);
        display_flag_next = 1'b0;
        menu_index_next   = abmc_pkg::MENU_DISPLAY;
        clr               = 1'b1;
      end else if (poll.menu_release) begin
        beeps = 2'(key_beep);
        if (halted_flag) begin
          halted_flag_next = 1'b0;
          rem              = (preset_store != 13'd0) ? preset_store : 13'd1;
          reload           = 1'b1;
        end
        menu_index_next = abmc_pkg::wrap_index(menu_index, abmc_pkg::MENU_ENTRIES);
      end else begin
        if (up_event) begin
          beeps = beeps + 2'(key_beep);
          adj   = adjust_step(adj, 1'b1, menu_index);
        end
        if (down_event) begin
          beeps = beeps + 2'(key_beep);
          adj   = adjust_step(adj, 1'b0, menu_index);
        end
        target_store_next = adj.tgt;
        if (adj.touched) begin
          rem               = 13'(adj.hrs) * 13'(abmc_pkg::MINUTES_PER_HOUR) + 13'(adj.mins);
          reload            = 1'b1;
          preset_store_next = rem;
        end
      end
    end

    result_next.powered            = power_flag_next;
    result_next.display_on         = display_flag_next;
    result_next.settings_active    = settings_flag_next;
    result_next.countdown_halted   = halted_flag_next;
    result_next.menu_position      = menu_index_next;
    result_next.target_temperature = target_store_next;
    result_next.timer_preset       = preset_store_next;
    result_next.remaining_out      = rem;
    result_next.seconds_reload     = reload;
    result_next.beep_count         = beeps;
    result_next.screen_clear       = clr;
    result_next.option_bits        = option_store_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_flag    <= 1'b0;
      display_flag  <= 1'b0;
      settings_flag <= 1'b0;
      halted_flag   <= 1'b0;
      menu_index    <= abmc_pkg::MENU_DISPLAY;
      target_store  <= 7'd0;
      preset_store  <= 13'd0;
      option_store  <= 3'd0;
      result_valid  <= 1'b0;
    end else begin
      if (accept) begin
        power_flag    <= power_flag_next;
        display_flag  <= display_flag_next;
        settings_flag <= settings_flag_next;
        halted_flag   <= halted_flag_next;
        menu_index    <= menu_index_next;
        target_store  <= target_store_next;
        preset_store  <= preset_store_next;
        option_store  <= option_store_next;
        result_valid  <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

`ifndef ASSERT_OFF
  a_settings_implies_power: assert property (@(posedge clk) disable iff (rst)
    settings_flag |-> power_flag)
    else $error("Settings mode is active while the unit is off.");

  a_target_in_range: assert property (@(posedge clk) disable iff (rst)
    target_store <= abmc_pkg::MAX_TARGET)
    else $error("Target temperature left its range.");

  a_accept_fills_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("An accepted beat produced no result.");

  a_power_off: assert property (@(posedge clk) disable iff (rst)
    accept && poll.power_press && power_flag |=> !power_flag && result.screen_clear)
    else $error("The power key did not switch the unit off.");

  a_beep_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.beep_count != 2'd3)
    else $error("More than two beeps requested in one beat.");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the appliance button menu controller with a built-in predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES     = 12;
  localparam int RANDOM_PER_PHASE = 434;
  localparam int DRIFT_SPAN       = 60;
  localparam int HOLD_CYCLES      = 300;
  localparam int STALL_LIMIT      = 2000;
  localparam int TAIL_CYCLES      = 8;

  localparam logic [7:0] K_PWR   = 8'b1000_0000;
  localparam logic [7:0] K_MREL  = 8'b0100_0000;
  localparam logic [7:0] K_MLONG = 8'b0010_0000;
  localparam logic [7:0] K_UREL  = 8'b0001_0000;
  localparam logic [7:0] K_UREP  = 8'b0000_1000;
  localparam logic [7:0] K_DREL  = 8'b0000_0100;
  localparam logic [7:0] K_DREP  = 8'b0000_0010;
  localparam logic [7:0] K_HELD  = 8'b0000_0001;

  typedef enum logic [1:0] {DRIFT_MIX, DRIFT_UP, DRIFT_DOWN} drift_t;

  typedef struct {
    abmc_pkg::poll_t   stim;
    bit                pinned;
    abmc_pkg::result_t want;
  } scripted_poll_t;

  logic              clk;
  logic              rst;
  logic              poll_valid;
  logic              poll_ready;
  abmc_pkg::poll_t   poll;
  logic              result_valid;
  logic              result_ready;
  abmc_pkg::result_t result;

  appliance_button_menu_controller_unit dut (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_ready   (poll_ready),
    .poll         (poll),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  logic        st_power;
  logic        st_display;
  logic        st_settings;
  logic        st_halted;
  logic [1:0]  menu_idx;
  logic [6:0]  set_point;
  logic [12:0] preset_min;
  logic [2:0]  opts;

  abmc_pkg::result_t expected_results[$];
  scripted_poll_t    directed_polls[$];
  abmc_pkg::result_t seen_want;
  int                fails;
  int                send_idle_pct;
  int                recv_idle_pct;
  bit                hold_req;
  drift_t            drift;
  logic [12:0]       rem_hint;

  always #5ns clk = ~clk;

  function automatic int unsigned click();
    return opts[abmc_pkg::KEY_SOUND_OFF_BIT] ? 0 : 1;
  endfunction

  task automatic go_dark(output logic clr);
    st_power    = 1'b0;
    st_display  = 1'b0;
    st_settings = 1'b0;
    st_halted   = 1'b1;
    clr         = 1'b1;
  endtask

  task automatic restart_countdown(inout logic [12:0] rem, inout logic reload);
    st_halted = 1'b0;
    rem       = (preset_min != 0) ? preset_min : 13'd1;
    reload    = 1'b1;
  endtask

  task automatic nudge_setting(input bit up, inout logic [12:0] rem, inout logic reload);
    int unsigned mins;
    int unsigned hrs;
    bit          moved;
    mins  = rem % abmc_pkg::MINUTES_PER_HOUR;
    hrs   = rem / abmc_pkg::MINUTES_PER_HOUR;
    moved = 1'b1;
    if (hrs > abmc_pkg::MAX_HOURS) hrs = abmc_pkg::MAX_HOURS;
    case (menu_idx)
      abmc_pkg::MENU_TARGET: begin
        moved = 1'b0;
        if (up && set_point < abmc_pkg::MAX_TARGET) set_point = set_point + 7'd1;
        else if (!up && set_point != 0) set_point = set_point - 7'd1;
      end
      abmc_pkg::MENU_HOURS: begin
        if (up) hrs = (hrs < abmc_pkg::MAX_HOURS) ? hrs + 1 : 0;
        else hrs = (hrs > 0) ? hrs - 1 : abmc_pkg::MAX_HOURS;
      end
      abmc_pkg::MENU_MINUTES: begin
        if (up) mins = (mins < abmc_pkg::MAX_MINUTES) ? mins + 1 : 0;
        else mins = (mins > 0) ? mins - 1 : abmc_pkg::MAX_MINUTES;
      end
      default: begin
        moved = 1'b0;
      end
    endcase
    if (moved) begin
      reload     = 1'b1;
      rem        = 13'(hrs * abmc_pkg::MINUTES_PER_HOUR + mins);
      preset_min = rem;
    end
  endtask

  task automatic predict_poll(input abmc_pkg::poll_t p, output abmc_pkg::result_t r);
    logic [12:0] rem;
    logic        reload;
    logic        clr;
    int unsigned beeps;
    rem    = p.remaining_in;
    reload = 1'b0;
    clr    = 1'b0;
    beeps  = 0;
    if (st_settings) begin
      if (p.power_press) begin
        go_dark(clr);
      end else if (p.menu_release) begin
        menu_idx = 2'((int'(menu_idx) + 1) % abmc_pkg::OPTION_ENTRIES);
      end else if (p.up_release || p.down_release) begin
        if (menu_idx < abmc_pkg::OPTION_BITS) opts = opts ^ (3'd1 << menu_idx);
      end
    end else if (p.power_press) begin
      if (st_power) begin
        beeps += click();
        go_dark(clr);
      end else if (p.menu_held) begin
        st_settings = 1'b1;
        st_power    = 1'b1;
        st_display  = 1'b1;
        st_halted   = 1'b0;
      end else begin
        beeps += click();
        st_power   = 1'b1;
        st_display = 1'b1;
        restart_countdown(rem, reload);
      end
    end else if (st_power) begin
      if (!st_display) begin
        if (p.up_release || p.down_release || p.menu_release) begin
          beeps += click();
          st_display = 1'b1;
        end
      end else if (p.menu_long_press) begin
        beeps += click();
        st_display = 1'b0;
        menu_idx   = abmc_pkg::MENU_DISPLAY;
        clr        = 1'b1;
      end else if (p.menu_release) begin
        beeps += click();
        if (st_halted) restart_countdown(rem, reload);
        menu_idx = 2'((int'(menu_idx) + 1) % abmc_pkg::MENU_ENTRIES);
      end else begin
        if (p.up_release || p.up_repeat) begin
          beeps += click();
          nudge_setting(1'b1, rem, reload);
        end
        if (p.down_release || p.down_repeat) begin
          beeps += click();
          nudge_setting(1'b0, rem, reload);
        end
      end
    end
    r.powered            = st_power;
    r.display_on         = st_display;
    r.settings_active    = st_settings;
    r.countdown_halted   = st_halted;
    r.menu_position      = menu_idx;
    r.target_temperature = set_point;
    r.timer_preset       = preset_min;
    r.remaining_out      = rem;
    r.seconds_reload     = reload;
    r.beep_count         = 2'(beeps);
    r.screen_clear       = clr;
    r.option_bits        = opts;
  endtask

  function automatic abmc_pkg::poll_t mk_poll(logic [7:0] keys, logic [12:0] rem);
    return abmc_pkg::poll_t'({keys, rem});
  endfunction

  task automatic add_row(logic [7:0] keys, logic [12:0] rem);
    scripted_poll_t row;
    row.stim   = mk_poll(keys, rem);
    row.pinned = 1'b0;
    row.want   = '0;
    directed_polls.push_back(row);
  endtask

  task automatic gen_poll(output abmc_pkg::poll_t p);
    logic [7:0]  keys;
    logic [12:0] rem;
    int          k;
    keys = '0;
    k    = $urandom_range(0, 99);
    if (drift == DRIFT_UP && k < 85) begin
      keys = $urandom_range(0, 1) ? K_UREL : K_UREP;
    end else if (drift == DRIFT_DOWN && k < 85) begin
      keys = $urandom_range(0, 1) ? K_DREL : K_DREP;
    end else begin
      k = $urandom_range(0, 99);
      if (k < 5) keys = K_PWR | (($urandom_range(0, 2) == 0) ? K_HELD : 8'd0);
      else if (k < 20) keys = K_MREL;
      else if (k < 23) keys = K_MLONG;
      else if (k < 45) keys = $urandom_range(0, 1) ? K_UREL : K_UREP;
      else if (k < 67) keys = $urandom_range(0, 1) ? K_DREL : K_DREP;
      else if (k < 73) keys = ($urandom_range(0, 1) ? K_UREL : K_UREP)
                            | ($urandom_range(0, 1) ? K_DREL : K_DREP);
      else if (k < 87) keys = 8'($urandom());
    end
    if ($urandom_range(0, 9) == 0) keys = keys | K_HELD;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: rem = rem_hint;
      6, 7: rem = 13'($urandom_range(0, 5999));
      8: rem = 13'($urandom());
      default: begin
        case ($urandom_range(0, 4))
          0: rem = 13'd0;
          1: rem = 13'd5999;
          2: rem = 13'h1FFF;
          3: rem = 13'd59;
          default: rem = 13'd5940;
        endcase
      end
    endcase
    p = mk_poll(keys, rem);
  endtask

  task automatic send_poll(input abmc_pkg::poll_t p, input bit pinned,
                           input abmc_pkg::result_t want);
    abmc_pkg::result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      poll_valid <= 1'b0;
      @(posedge clk);
    end
    poll_valid <= 1'b1;
    poll       <= p;
    @(posedge clk);
    while (!poll_ready) @(posedge clk);
    predict_poll(p, r);
    rem_hint = r.remaining_out;
    expected_results.push_back(pinned ? want : r);
  endtask

  task automatic drain_results();
    poll_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic compare_field(string name, logic [12:0] want, logic [12:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Every result beat is matched against the oldest pending prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no poll pending");
        fails++;
      end else begin
        seen_want = expected_results.pop_front();
        compare_field("powered", seen_want.powered, result.powered);
        compare_field("display_on", seen_want.display_on, result.display_on);
        compare_field("settings_active", seen_want.settings_active, result.settings_active);
        compare_field("countdown_halted", seen_want.countdown_halted,
                      result.countdown_halted);
        compare_field("menu_position", seen_want.menu_position, result.menu_position);
        compare_field("target_temperature", seen_want.target_temperature,
                      result.target_temperature);
        compare_field("timer_preset", seen_want.timer_preset, result.timer_preset);
        compare_field("remaining_out", seen_want.remaining_out, result.remaining_out);
        compare_field("seconds_reload", seen_want.seconds_reload, result.seconds_reload);
        compare_field("beep_count", seen_want.beep_count, result.beep_count);
        compare_field("screen_clear", seen_want.screen_clear, result.screen_clear);
        compare_field("option_bits", seen_want.option_bits, result.option_bits);
      end
    end
  end

  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          result_ready <= 1'b0;
          @(posedge clk);
        end
      end
      result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (poll_valid && poll_ready) || (result_valid && result_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("appliance_button_menu_controller_unit verification failed");
    $finish;
  end

  initial begin
    scripted_poll_t    row;
    abmc_pkg::result_t pin;
    abmc_pkg::poll_t   p;
    clk           = 1'b0;
    rst           = 1'b1;
    poll_valid    = 1'b0;
    poll          = '0;
    fails         = 0;
    hold_req      = 1'b0;
    drift         = DRIFT_MIX;
    rem_hint      = '0;
    send_idle_pct = 32;
    recv_idle_pct = 78;
    st_power      = 1'b0;
    st_display    = 1'b0;
    st_settings   = 1'b0;
    st_halted     = 1'b0;
    menu_idx      = abmc_pkg::MENU_DISPLAY;
    set_point     = '0;
    preset_min    = '0;
    opts          = '0;

    row.stim   = mk_poll(8'd0, 13'd0);
    row.pinned = 1'b1;
    row.want   = '0;
    directed_polls.push_back(row);

    pin                = '0;
    pin.powered        = 1'b1;
    pin.display_on     = 1'b1;
    pin.remaining_out  = 13'd1;
    pin.seconds_reload = 1'b1;
    pin.beep_count     = 2'd1;
    row.stim           = mk_poll(K_PWR, 13'd5999);
    row.want           = pin;
    directed_polls.push_back(row);

    pin                  = '0;
    pin.countdown_halted = 1'b1;
    pin.remaining_out    = 13'h1FFF;
    pin.beep_count       = 2'd1;
    pin.screen_clear     = 1'b1;
    row.stim             = mk_poll(K_PWR, 13'h1FFF);
    row.want             = pin;
    directed_polls.push_back(row);

    add_row(K_PWR, 13'd0);
    add_row(K_MREL, 13'd1);
    add_row(K_DREL, 13'd1);
    add_row(K_UREL | K_DREL, 13'd1);
    add_row(K_UREP, 13'd1);
    add_row(K_MREL, 13'd1);
    add_row(K_UREL, 13'd5999);
    add_row(K_DREP, 13'h1FFF);
    add_row(K_DREL, 13'd0);
    add_row(K_MREL, 13'd5940);
    add_row(K_UREL, 13'd59);
    add_row(K_DREL, 13'd0);
    add_row(K_PWR, 13'd59);
    add_row(K_PWR | K_HELD, 13'd59);
    add_row(K_UREL, 13'd59);
    add_row(K_MREL, 13'd59);
    add_row(K_DREL, 13'd59);
    add_row(K_MREL, 13'd59);
    add_row(K_UREL | K_UREP, 13'd59);
    add_row(K_MREL, 13'd59);
    add_row(K_PWR, 13'd59);
    add_row(K_PWR, 13'd100);
    add_row(K_MLONG, 13'd100);
    add_row(K_DREL, 13'd100);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_polls[i]) begin
      send_poll(directed_polls[i].stim, directed_polls[i].pinned, directed_polls[i].want);
    end
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 78 : 0;
      recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 32 : 0;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (i % DRIFT_SPAN == 0) drift = drift_t'($urandom_range(0, 2));
        if (ph == 2 && i == 100) hold_req = 1'b1;
        gen_poll(p);
        send_poll(p, 1'b0, '0);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0 && expected_results.size() == 0) begin
      $display("appliance_button_menu_controller_unit verification clean");
    end else begin
      $display("appliance_button_menu_controller_unit verification failed");
    end
    $finish;
  end

endmodule
